>>> hw/rtl/tun_pkg.sv
package tun_pkg;

  localparam int CW   = 32;        // vertex coordinate width, Q16.16
  localparam int EW   = CW + 1;    // edge difference
  localparam int PW   = 2 * EW;    // edge product
  localparam int NW   = PW + 1;    // cross product component, signed
  localparam int MW   = PW;        // cross product magnitude
  localparam int HW   = MW / 2;    // half of the magnitude for partial products
  localparam int LW   = 132;       // squared magnitudes and squared length
  localparam int QW   = 63;        // quotient mag^2 * 2^62 / len^2
  localparam int DW   = QW + 1;    // radicand padded to an even width
  localparam int RW   = DW / 2;    // square root width
  localparam int SRW  = RW + 3;    // square root partial remainder
  localparam int OW   = 32;        // Q1.30 output component

  localparam int NDIV  = QW;       // one quotient bit per stage
  localparam int NSQ   = RW;       // one root bit per stage
  localparam int NLANE = NDIV + NSQ + 1;
  localparam int NPRE  = 7;
  localparam int NSTG  = NPRE + NLANE;

  localparam logic signed [OW-1:0] Q30_ONE = OW'(1) <<< 30;

  typedef struct packed {
    logic [LW-1:0] mag2;
    logic [LW-1:0] len2;
    logic          neg;
    logic          deg;
  } tun_lane_in_t;

  typedef struct packed {
    logic signed [OW-1:0] nx;
    logic signed [OW-1:0] ny;
    logic signed [OW-1:0] nz;
    logic                 degenerate;
  } tun_res_t;

endpackage

>>> hw/rtl/tun_ifs.sv
interface tun_tri_if;
  import tun_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] ax;
  logic signed [CW-1:0] ay;
  logic signed [CW-1:0] az;
  logic signed [CW-1:0] bx;
  logic signed [CW-1:0] by;
  logic signed [CW-1:0] bz;
  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic signed [CW-1:0] cz;

  modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, input ready);
  modport sink (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, output ready);
endinterface

interface tun_norm_if;
  import tun_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [OW-1:0] nx;
  logic signed [OW-1:0] ny;
  logic signed [OW-1:0] nz;
  logic                 degenerate;

  modport source (output valid, nx, ny, nz, degenerate, input ready);
  modport sink (input valid, nx, ny, nz, degenerate, output ready);
endinterface

>>> hw/rtl/tun_lane.sv
module tun_lane (
  input  logic                          clk,
  input  logic                          en,
  input  tun_pkg::tun_lane_in_t         lane_in,
  output logic signed [tun_pkg::OW-1:0] comp,
  output logic                          deg
);
  import tun_pkg::*;

  // tag bit 1 is the sign, bit 0 the degenerate flag
  logic [LW-1:0]  drem_r [NDIV];
  logic [LW-1:0]  dlen_r [NDIV];
  logic [QW-1:0]  dq_r   [NDIV];
  logic [1:0]     dtag_r [NDIV];

  logic [DW-1:0]  sd_r    [NSQ];
  logic [SRW-1:0] srem_r  [NSQ];
  logic [RW-1:0]  sroot_r [NSQ];
  logic [1:0]     stag_r  [NSQ];

  logic signed [OW-1:0] comp_r;
  logic                 deg_r;

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < NDIV; k++) begin : g_div
    logic [LW:0]   t;
    logic [LW-1:0] len;
    logic [QW-1:0] qin;
    logic [1:0]    tag;
    logic          ge;
    logic [LW:0]   diff;

    if (k == 0) begin : g_first
      assign t   = {1'b0, lane_in.mag2};
      assign len = lane_in.len2;
      assign qin = '0;
      assign tag = {lane_in.neg, lane_in.deg};
    end else begin : g_next
      assign t   = {drem_r[k-1], 1'b0};
      assign len = dlen_r[k-1];
      assign qin = dq_r[k-1];
      assign tag = dtag_r[k-1];
    end

    assign diff = t - {1'b0, len};
    assign ge   = t >= {1'b0, len};

    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[k] <= ge ? diff[LW-1:0] : t[LW-1:0];
        dlen_r[k] <= len;
        dq_r[k]   <= {qin[QW-2:0], ge};
        dtag_r[k] <= tag;
      end
    end
  end

  // digit-by-digit square root, one root bit per stage
  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    logic [DW-1:0]  rad;
    logic [SRW-1:0] rem;
    logic [RW-1:0]  root;
    logic [1:0]     tag;
    logic [SRW-1:0] remsh;
    logic [SRW-1:0] trial;
    logic           ge;

    if (j == 0) begin : g_first
      assign rad  = {1'b0, dq_r[NDIV-1]};
      assign rem  = '0;
      assign root = '0;
      assign tag  = dtag_r[NDIV-1];
    end else begin : g_next
      assign rad  = sd_r[j-1];
      assign rem  = srem_r[j-1];
      assign root = sroot_r[j-1];
      assign tag  = stag_r[j-1];
    end

    assign remsh = {rem[SRW-3:0], rad[DW-1:DW-2]};
    assign trial = {1'b0, root, 2'b01};
    assign ge    = remsh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        sd_r[j]    <= {rad[DW-3:0], 2'b00};
        srem_r[j]  <= ge ? remsh - trial : remsh;
        sroot_r[j] <= {root[RW-2:0], ge};
        stag_r[j]  <= tag;
      end
    end
  end

  // largest s with s^2 <= quotient gives the rounded component (s + 1) / 2
  logic [RW:0]   rnd;
  logic [OW-1:0] qmag;
  assign rnd  = {1'b0, sroot_r[NSQ-1]} + (RW+1)'(1);
  assign qmag = rnd[RW:1];

  always_ff @(posedge clk) begin
    if (en) begin
      deg_r <= stag_r[NSQ-1][0];
      if (stag_r[NSQ-1][0]) begin
        comp_r <= '0;
      end else if (stag_r[NSQ-1][1]) begin
        comp_r <= -$signed(qmag);
      end else begin
        comp_r <= $signed(qmag);
      end
    end
  end

  assign comp = comp_r;
  assign deg  = deg_r;

endmodule

>>> hw/rtl/triangle_unit_normal.sv
// Unit face normal of a triangle: takes three Q16.16 vertices a, b, c and returns
// (c-a) x (b-a) divided by its length as Q1.30 components, each rounded to nearest
// with ties away from zero; a zero cross product gives an all-zero normal with the
// degenerate flag set. The pipeline accepts one triangle every clock unless the
// input is held off, and a result may wait at the output until it is taken.
// Most of the pipeline depth is the exact division of the squared component by the
// squared length (63 stages, one quotient bit each) and the square root after it
// (32 stages, one root bit each). A two-entry output queue lets the pipeline keep
// moving while a result waits; the input is held off only while both entries are full.
module triangle_unit_normal (
  input  logic       clk,
  input  logic       rst_n,
  tun_tri_if.sink    in_ch,
  tun_norm_if.source out_ch
);
  import tun_pkg::*;

  logic            en;
  logic [NSTG-1:0] v_r;

  logic signed [EW-1:0] e_r [6];
  logic signed [PW-1:0] p_r [6];
  logic signed [NW-1:0] n_r [3];
  logic [MW-1:0]        mag_r [3];
  logic [2*HW-1:0]      hh_r [3];
  logic [2*HW-1:0]      hl_r [3];
  logic [2*HW-1:0]      ll_r [3];
  logic [LW-1:0]        sq_r [3];
  logic [LW-1:0]        m2_r [3];
  logic [LW-1:0]        len2_r;
  logic [2:0]           ng3_r, ng4_r, ng5_r, ng6_r;

  tun_lane_in_t         lane_in [3];
  logic signed [OW-1:0] comp [3];
  logic                 ldeg [3];

  tun_res_t pipe_res;
  tun_res_t ob_r, sk_r;
  logic     ob_v_r, sk_v_r;
  logic     ob_free;

  assign en          = !sk_v_r;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // edge vectors u = b - a, v = c - a
      e_r[0] <= EW'(in_ch.bx) - EW'(in_ch.ax);
      e_r[1] <= EW'(in_ch.by) - EW'(in_ch.ay);
      e_r[2] <= EW'(in_ch.bz) - EW'(in_ch.az);
      e_r[3] <= EW'(in_ch.cx) - EW'(in_ch.ax);
      e_r[4] <= EW'(in_ch.cy) - EW'(in_ch.ay);
      e_r[5] <= EW'(in_ch.cz) - EW'(in_ch.az);

      p_r[0] <= PW'(e_r[4]) * PW'(e_r[2]);
      p_r[1] <= PW'(e_r[1]) * PW'(e_r[5]);
      p_r[2] <= PW'(e_r[5]) * PW'(e_r[0]);
      p_r[3] <= PW'(e_r[3]) * PW'(e_r[2]);
      p_r[4] <= PW'(e_r[3]) * PW'(e_r[1]);
      p_r[5] <= PW'(e_r[4]) * PW'(e_r[0]);

      for (int i = 0; i < 3; i++) begin
        n_r[i]   <= NW'(p_r[2*i]) - NW'(p_r[2*i+1]);
        ng3_r[i] <= n_r[i][NW-1];
        mag_r[i] <= n_r[i][NW-1] ? MW'(-n_r[i]) : MW'(n_r[i]);
        hh_r[i]  <= (2*HW)'(mag_r[i][MW-1:HW]) * (2*HW)'(mag_r[i][MW-1:HW]);
        hl_r[i]  <= (2*HW)'(mag_r[i][MW-1:HW]) * (2*HW)'(mag_r[i][HW-1:0]);
        ll_r[i]  <= (2*HW)'(mag_r[i][HW-1:0]) * (2*HW)'(mag_r[i][HW-1:0]);
        sq_r[i]  <= (LW'(hh_r[i]) << (2*HW)) + (LW'(hl_r[i]) << (HW+1)) + LW'(ll_r[i]);
        m2_r[i]  <= sq_r[i];
      end
      ng4_r  <= ng3_r;
      ng5_r  <= ng4_r;
      ng6_r  <= ng5_r;
      len2_r <= sq_r[0] + sq_r[1] + sq_r[2];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign lane_in[i] = '{mag2: m2_r[i], len2: len2_r, neg: ng6_r[i], deg: ~|len2_r};

    tun_lane u_lane (
      .clk     (clk),
      .en      (en),
      .lane_in (lane_in[i]),
      .comp    (comp[i]),
      .deg     (ldeg[i])
    );
  end

  assign pipe_res = '{nx: comp[0], ny: comp[1], nz: comp[2], degenerate: ldeg[0]};

  // output register with one skid entry behind it
  assign ob_free = !ob_v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_v_r <= 1'b0;
      sk_v_r <= 1'b0;
    end else if (sk_v_r) begin
      if (ob_free) begin
        ob_v_r <= 1'b1;
        sk_v_r <= 1'b0;
      end
    end else if (v_r[NSTG-1]) begin
      if (ob_free) begin
        ob_v_r <= 1'b1;
      end else begin
        sk_v_r <= 1'b1;
      end
    end else if (ob_free) begin
      ob_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_v_r) begin
      if (ob_free) begin
        ob_r <= sk_r;
      end
    end else if (ob_free) begin
      ob_r <= pipe_res;
    end else begin
      sk_r <= pipe_res;
    end
  end

  assign out_ch.valid      = ob_v_r;
  assign out_ch.nx         = ob_r.nx;
  assign out_ch.ny         = ob_r.ny;
  assign out_ch.nz         = ob_r.nz;
  assign out_ch.degenerate = ob_r.degenerate;

  a_skid_behind_full: assert property (@(posedge clk) disable iff (!rst_n)
    sk_v_r |-> ob_v_r) else $error("skid entry holds a result while output is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sk_v_r) |-> $past(ob_v_r && !out_ch.ready))
    else $error("skid filled while output could take the result");

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.degenerate |-> out_ch.nx == '0 && out_ch.ny == '0 && out_ch.nz == '0)
    else $error("degenerate normal not zero");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.nx <= Q30_ONE && out_ch.nx >= -Q30_ONE &&
                     out_ch.ny <= Q30_ONE && out_ch.ny >= -Q30_ONE &&
                     out_ch.nz <= Q30_ONE && out_ch.nz >= -Q30_ONE)
    else $error("normal component outside unit range");

endmodule
